### hdl/icd_pkg.sv
// Package for the input chord detector: field widths, operation and mode codes,
// and the struct passed from the front end to the back end. No dependencies.
package icd_pkg;

  localparam int MaxShortcutsDef = 8;
  localparam int SlotsPerShortcutDef = 4;
  localparam int DeviceIdsDef = 16;

  localparam int EntryW = 3;
  localparam int SlotW = 2;
  localparam int TypeW = 8;
  localparam int CodeW = 10;
  localparam int ValueW = 16;
  localparam int TrigHiW = 15;
  localparam int MaskW = 16;
  localparam int DevW = 4;

  typedef enum logic [1:0] {
    OP_EVENT  = 2'd0,
    OP_SLOT   = 2'd1,
    OP_HEADER = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_SIM  = 2'd1,
    MODE_CONS = 2'd2,
    MODE_BAD  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

  // One classified item in the queue; only input events and in-range
  // table writes are queued. The last member sits in the lowest bits, so the
  // operation occupies bits 1:0 of the packed item.
  typedef struct packed {
    logic [MaskW-1:0]         mask;
    mode_t                    mode;
    logic [TrigHiW-1:0]       trig_hi;
    logic signed [ValueW-1:0] trig_lo;
    logic                     slot_valid;
    logic [SlotW-1:0]         slot;
    logic [EntryW-1:0]        entry;
    logic signed [ValueW-1:0] value;
    logic [CodeW-1:0]         ecode;
    logic [TypeW-1:0]         etype;
    logic [DevW-1:0]          dev;
    op_t                      op;
  } item_t;

  localparam int InW = 2 + DevW + TypeW + CodeW + ValueW + EntryW + SlotW + 1 + ValueW
                       + TrigHiW + 2 + MaskW;
  localparam int InBytesW = ((InW + 7) / 8) * 8;

endpackage

### hdl/icd_front.sv
// Front end of the chord detector: accepts items, unpacks and filters them,
// and holds them in a small queue. Depends on icd_pkg.
module icd_front #(
  parameter int MAX_SHORTCUTS = icd_pkg::MaxShortcutsDef,
  parameter int SLOTS_PER_SHORTCUT = icd_pkg::SlotsPerShortcutDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [icd_pkg::InBytesW-1:0] in_tdata,
  output logic                       q_valid,
  input  logic                       q_pop,
  output icd_pkg::item_t             q_item
);
  import icd_pkg::*;

  localparam int Depth = 2;

  item_t      mem_r [Depth];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  item_t      it;
  logic       keep, push;

  assign it = item_t'(in_tdata[InW-1:0]);

  always_comb begin
    case (it.op)
      OP_EVENT:  keep = 1'b1;
      OP_SLOT:   keep = (32'(it.entry) < MAX_SHORTCUTS) &&
                        (32'(it.slot) < SLOTS_PER_SHORTCUT);
      OP_HEADER: keep = 32'(it.entry) < MAX_SHORTCUTS;
      default:   keep = 1'b0;
    endcase
  end

  assign in_tready = (cnt_r != 2'(Depth));
  assign push = in_tvalid && in_tready && keep;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= it;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("queue popped while empty");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'(Depth))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) (push && !q_pop) |=> q_valid)
    else $error("pushed item not visible");

endmodule

### hdl/icd_back.sv
// Back end of the chord detector: holds the shortcut table and walks the
// entries one per cycle for each event, unless a pending result cannot move out. Depends on icd_pkg.
module icd_back #(
  parameter int MAX_SHORTCUTS = icd_pkg::MaxShortcutsDef,
  parameter int SLOTS_PER_SHORTCUT = icd_pkg::SlotsPerShortcutDef,
  parameter int DEVICE_IDS = icd_pkg::DeviceIdsDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  icd_pkg::item_t             q_item,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,
  output logic                       out_tlast
);
  import icd_pkg::*;

  localparam int EW = (MAX_SHORTCUTS > 1) ? $clog2(MAX_SHORTCUTS) : 1;

  state_t state_r, state_nxt;
  logic [EW-1:0] idx_r, idx_nxt;
  item_t         ev_r;

  logic                     s_valid_r [MAX_SHORTCUTS][SLOTS_PER_SHORTCUT];
  logic                     s_press_r [MAX_SHORTCUTS][SLOTS_PER_SHORTCUT];
  logic [TypeW-1:0]         s_type_r  [MAX_SHORTCUTS][SLOTS_PER_SHORTCUT];
  logic [CodeW-1:0]         s_code_r  [MAX_SHORTCUTS][SLOTS_PER_SHORTCUT];
  logic signed [ValueW-1:0] s_lo_r    [MAX_SHORTCUTS][SLOTS_PER_SHORTCUT];
  logic [TrigHiW-1:0]       s_hi_r    [MAX_SHORTCUTS][SLOTS_PER_SHORTCUT];
  mode_t                    h_mode_r  [MAX_SHORTCUTS];
  logic [MaskW-1:0]         h_mask_r  [MAX_SHORTCUTS];

  // Pending result held until a later fire sends it out, or the end of the scan sends it with tlast set.
  logic          pend_r, pend_nxt;
  logic [EW-1:0] pidx_r, pidx_nxt;
  logic          ov_r, ov_nxt;
  logic [2:0]    od_r, od_nxt;
  logic          ol_r, ol_nxt;

  logic dev_ok, active, all_pr, fire, emit_ok;
  logic new_press [SLOTS_PER_SHORTCUT];
  logic hit [SLOTS_PER_SHORTCUT];

  always_comb begin
    if (h_mask_r[idx_r] == {MaskW{1'b1}}) dev_ok = 1'b1;
    else if (32'(ev_r.dev) >= DEVICE_IDS) dev_ok = 1'b0;
    else dev_ok = h_mask_r[idx_r][ev_r.dev];
    active = (h_mode_r[idx_r] == MODE_SIM || h_mode_r[idx_r] == MODE_CONS) && dev_ok;
    all_pr = 1'b1;
    for (int j = 0; j < SLOTS_PER_SHORTCUT; j++) begin
      hit[j] = s_valid_r[idx_r][j] && s_type_r[idx_r][j] == ev_r.etype &&
               s_code_r[idx_r][j] == ev_r.ecode;
      if (s_lo_r[idx_r][j] < 0 || s_hi_r[idx_r][j] != '0)
        new_press[j] = (s_lo_r[idx_r][j] < 0 && ev_r.value <= s_lo_r[idx_r][j]) ||
                       (s_hi_r[idx_r][j] != '0 &&
                        ev_r.value >= $signed({1'b0, s_hi_r[idx_r][j]}));
      else
        new_press[j] = ev_r.value != '0;
      if (s_valid_r[idx_r][j] && !(hit[j] ? new_press[j] : s_press_r[idx_r][j]))
        all_pr = 1'b0;
    end
    fire = active && h_mode_r[idx_r] == MODE_SIM && all_pr;
  end

  assign emit_ok = !ov_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    pend_nxt = pend_r;
    pidx_nxt = pidx_r;
    ov_nxt = ov_r && !out_tready;
    od_nxt = od_r;
    ol_nxt = ol_r;
    q_pop = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == OP_EVENT) begin
            state_nxt = ST_SCAN;
            idx_nxt = '0;
          end
        end
      end
      ST_SCAN: begin
        // Stall the walk while the entry fires, a result is pending and the output cannot take it.
        if (!(fire && pend_r && !emit_ok)) begin
          if (fire) begin
            if (pend_r) begin
              ov_nxt = 1'b1;
              od_nxt = 3'(pidx_r);
              ol_nxt = 1'b0;
            end
            pend_nxt = 1'b1;
            pidx_nxt = idx_r;
          end
          if (32'(idx_r) == MAX_SHORTCUTS - 1) state_nxt = ST_FLUSH;
          else idx_nxt = idx_r + 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!pend_r) state_nxt = ST_IDLE;
        else if (emit_ok) begin
          ov_nxt = 1'b1;
          od_nxt = 3'(pidx_r);
          ol_nxt = 1'b1;
          pend_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic scan_step;
  assign scan_step = state_r == ST_SCAN && !(fire && pend_r && !emit_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r <= '0;
      pend_r <= 1'b0;
      ov_r <= 1'b0;
      for (int i = 0; i < MAX_SHORTCUTS; i++) begin
        h_mode_r[i] <= MODE_OFF;
        h_mask_r[i] <= '0;
        for (int j = 0; j < SLOTS_PER_SHORTCUT; j++) begin
          s_valid_r[i][j] <= 1'b0;
          s_press_r[i][j] <= 1'b0;
        end
      end
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      pend_r <= pend_nxt;
      ov_r <= ov_nxt;
      if (q_pop && q_item.op == OP_SLOT) begin
        s_valid_r[EW'(q_item.entry)][SlotW'(q_item.slot)] <= q_item.slot_valid;
        s_press_r[EW'(q_item.entry)][SlotW'(q_item.slot)] <= 1'b0;
      end
      if (q_pop && q_item.op == OP_HEADER) begin
        h_mode_r[EW'(q_item.entry)] <= q_item.mode;
        h_mask_r[EW'(q_item.entry)] <= q_item.mask;
      end
      if (scan_step && active) begin
        for (int j = 0; j < SLOTS_PER_SHORTCUT; j++) begin
          if (hit[j]) s_press_r[idx_r][j] <= new_press[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= pidx_nxt;
    od_r <= od_nxt;
    ol_r <= ol_nxt;
    if (q_pop && q_item.op == OP_EVENT) ev_r <= q_item;
    if (q_pop && q_item.op == OP_SLOT) begin
      s_type_r[EW'(q_item.entry)][SlotW'(q_item.slot)] <= q_item.etype;
      s_code_r[EW'(q_item.entry)][SlotW'(q_item.slot)] <= q_item.ecode;
      s_lo_r[EW'(q_item.entry)][SlotW'(q_item.slot)] <= q_item.trig_lo;
      s_hi_r[EW'(q_item.entry)][SlotW'(q_item.slot)] <= q_item.trig_hi;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {5'd0, od_r};
  assign out_tlast = ol_r;

  assert property (@(posedge clk) disable iff (!rst_n) (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> state_r == ST_IDLE)
    else $error("queue read during scan");
  assert property (@(posedge clk) disable iff (!rst_n) (state_r == ST_IDLE) |-> !pend_r)
    else $error("pending result left after scan");

endmodule

### hdl/input_chord_detector.sv
// Input chord detector top level: front end queue feeding the table walker.
// Depends on icd_pkg, icd_front and icd_back.
// The walker checks an event against all entries, one entry per cycle unless a pending
// result cannot move out; the queue holds further items until the walker is idle again.
// Synchronous active-low reset clears the queue, all slot valid and pressed bits,
// and all headers to disabled with a zero device mask.
module input_chord_detector #(
  parameter int MAX_SHORTCUTS = icd_pkg::MaxShortcutsDef,
  parameter int SLOTS_PER_SHORTCUT = icd_pkg::SlotsPerShortcutDef,
  parameter int DEVICE_IDS = icd_pkg::DeviceIdsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // operation, device_id, event_type, event_code, event_value, entry_index,
  // slot_index, slot_valid, low threshold, high threshold, group_mode, allowed_devices
  input  logic [icd_pkg::InBytesW-1:0] in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // fired_shortcut
  output logic [7:0]                   out_tdata,
  output logic                         out_tlast
);
  import icd_pkg::*;

  logic  q_valid, q_pop;
  item_t q_item;

  icd_front #(.MAX_SHORTCUTS(MAX_SHORTCUTS), .SLOTS_PER_SHORTCUT(SLOTS_PER_SHORTCUT)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .q_valid, .q_pop, .q_item
  );

  icd_back #(.MAX_SHORTCUTS(MAX_SHORTCUTS), .SLOTS_PER_SHORTCUT(SLOTS_PER_SHORTCUT),
             .DEVICE_IDS(DEVICE_IDS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_item, .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule
